// ===== sv/mrat_pkg.sv =====
package mrat_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int IDX_W = $clog2(MAX_REGIONS);

    typedef enum logic [2:0] {
        OP_INSERT      = 3'd0,
        OP_LOOKUP      = 3'd1,
        OP_ENABLE      = 3'd2,
        OP_DISABLE     = 3'd3,
        OP_DELETE      = 3'd4,
        OP_CLEAR_ALL   = 3'd5,
        OP_ENABLE_ALL  = 3'd6,
        OP_DISABLE_ALL = 3'd7
    } op_t;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BOUNDS     = 3'd1;
    localparam logic [2:0] ST_OVERLAP    = 3'd2;
    localparam logic [2:0] ST_MISALIGNED = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [2:0] ST_FULL       = 3'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] addr_low;
        logic [63:0] addr_high;
        logic [63:0] address;
        logic [15:0] region_number;
        logic [1:0]  access_mode;
        logic [2:0]  access_width;
        logic        cacheable;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [63:0] result_low;
        logic [63:0] result_high;
        logic [15:0] result_number;
        logic [1:0]  result_mode;
        logic [2:0]  result_width;
        logic        result_cache;
        logic        attr_unknown;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic               load;   // capture command, reset scan state
        logic               scan;   // examine entry at idx
        logic [IDX_W-1:0]   idx;
        logic               finish; // apply result and update table
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic               early;  // scan may stop (lookup hit)
        logic               single; // op needs no scan
    } sts_t;

endpackage

// ===== sv/memory_region_attribute_table.sv =====
// Memory region attribute table.
// Command channel: raise start with cmd (mode plus operands) while busy is low;
// the beat is taken on that edge and busy rises on the next cycle.
// Result channel: done pulses high for one cycle with result valid; the
// receiver cannot stall, so capture it on that cycle.
// Commands without a table walk (clear/enable/disable all, an insert failing
// the bounds or alignment check) go from load straight to finish; others
// walk the 16 slots one per cycle, a lookup stopping at the slot that hits.
// One command at a time: busy drops while done is high, so the next beat
// can be taken on the result edge; the slot walk through the controller's
// index counter sets the rate.
// Configuration: cfg_we writes cfg_data[0] to unknown_inaccessible; write
// only while idle.
// Reset: all slots empty, next number 0, unknown_inaccessible set.
module memory_region_attribute_table
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  mrat_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done,
    output mrat_pkg::rsp_t result,
    input  logic           cfg_we,
    input  logic           cfg_data
);

    mrat_pkg::ctl_t ctl;
    mrat_pkg::sts_t sts;
    logic           unk_reg;

    // hold configuration bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            unk_reg <= 1'b1;
        else if (cfg_we)
            unk_reg <= cfg_data;
    end

    mrat_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    mrat_dp u_dp
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .unknown_inaccessible (unk_reg),
        .ctl                  (ctl),
        .sts                  (sts),
        .result               (result),
        .done                 (done)
    );

endmodule

// ===== sv/mrat_ctrl.sv =====
module mrat_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mrat_pkg::sts_t     sts,
    output mrat_pkg::ctl_t     ctl,
    output logic               busy
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOAD   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [mrat_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       last;

    assign last = (idx_reg == mrat_pkg::IDX_W'(mrat_pkg::MAX_REGIONS - 1));

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ctl        = '0;
        ctl.idx    = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOAD;
                    ctl.load   = 1'b1;
                end
            end
            S_LOAD:
            begin
                idx_next   = '0;
                state_next = sts.single ? S_FINISH : S_SCAN;
            end
            S_SCAN:
            begin
                ctl.scan = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (last || sts.early)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // start is sampled only in idle, so busy is any other state
    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_load_after: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> state_reg == S_LOAD)
        else $error("load not followed by load state");
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> !busy)
        else $error("finish did not return to idle");

endmodule

// ===== sv/mrat_dp.sv =====
module mrat_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  mrat_pkg::cmd_t     cmd,
    input  logic               unknown_inaccessible,
    input  mrat_pkg::ctl_t     ctl,
    output mrat_pkg::sts_t     sts,
    output mrat_pkg::rsp_t     result,
    output logic               done
);

    localparam int N = mrat_pkg::MAX_REGIONS;

    mrat_pkg::cmd_t   c_reg;
    logic [N-1:0]     valid_reg;
    logic [N-1:0]     en_reg;
    logic [63:0]      lo_mem  [N];
    logic [63:0]      hi_mem  [N];
    logic [15:0]      num_mem [N];
    logic [5:0]       att_mem [N];
    logic [15:0]      next_number_reg;

    // scan accumulators
    logic             hit_reg, ovl_reg, any_reg, sel_reg;
    logic [mrat_pkg::IDX_W-1:0] sel_idx_reg;
    logic [N-1:0]     match_reg;
    logic [63:0]      gap_lo_reg, gap_hi_reg;
    logic [63:0]      hit_lo_reg, hit_hi_reg;
    logic [15:0]      hit_num_reg;
    logic [5:0]       hit_att_reg;

    logic [1:0]       amode;
    logic [2:0]       awidth;
    logic [2:0]       mask;
    logic             misaligned, bad_bounds;
    logic [63:0]      elo, ehi;
    logic             ev, ee, e_ovl, e_cov, e_num;
    logic [mrat_pkg::IDX_W-1:0] free_idx;
    logic             free_any;
    logic [15:0]      num_inc;
    logic [2:0]       st;
    mrat_pkg::op_t    op;
    mrat_pkg::rsp_t   rsp_next;

    assign op     = mrat_pkg::op_t'(c_reg.mode);
    assign amode  = (c_reg.access_mode == 2'd3) ? 2'd0 : c_reg.access_mode;
    assign awidth = (c_reg.access_width > 3'd4) ? 3'd0 : c_reg.access_width;

    always_comb
    begin
        unique case (awidth)
            3'd2:    mask = 3'd1;
            3'd3:    mask = 3'd3;
            3'd4:    mask = 3'd7;
            default: mask = 3'd0;
        endcase
    end

    assign misaligned = ((c_reg.addr_low[2:0] & mask) != 3'd0)
                     || ((c_reg.addr_high[2:0] & mask) != 3'd0);
    assign bad_bounds = (c_reg.addr_low >= c_reg.addr_high) && (c_reg.addr_high != 64'd0);

    assign elo   = lo_mem[ctl.idx];
    assign ehi   = hi_mem[ctl.idx];
    assign ev    = valid_reg[ctl.idx];
    assign ee    = en_reg[ctl.idx];
    assign e_num = (num_mem[ctl.idx] == c_reg.region_number);
    assign e_cov = (c_reg.address >= elo) && ((c_reg.address < ehi) || (ehi == 64'd0));
    assign e_ovl = (c_reg.addr_low >= elo)
                 ? ((c_reg.addr_low < ehi) || (ehi == 64'd0))
                 : ((c_reg.addr_high > elo) || (c_reg.addr_high == 64'd0));

    assign sts.early  = (op == mrat_pkg::OP_LOOKUP) && ev && ee && e_cov;
    assign sts.single = (op == mrat_pkg::OP_CLEAR_ALL) || (op == mrat_pkg::OP_ENABLE_ALL)
                     || (op == mrat_pkg::OP_DISABLE_ALL)
                     || ((op == mrat_pkg::OP_INSERT) && (misaligned || bad_bounds));

    // lowest free slot; small priority search over valid bits
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = mrat_pkg::IDX_W'(i);
                free_any = 1'b1;
            end
        end
    end

    assign num_inc = (next_number_reg == 16'hFFFF) ? 16'd1 : next_number_reg + 16'd1;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            c_reg      <= cmd;
            hit_reg    <= 1'b0;
            ovl_reg    <= 1'b0;
            any_reg    <= 1'b0;
            sel_reg    <= 1'b0;
            match_reg  <= '0;
            gap_lo_reg <= 64'd0;
            gap_hi_reg <= 64'd0;
        end
        if (ctl.scan && ev)
        begin
            any_reg <= 1'b1;
            if (e_ovl)
                ovl_reg <= 1'b1;
            if (e_num)
            begin
                match_reg[ctl.idx] <= 1'b1;
                if (!sel_reg || (elo < lo_mem[sel_idx_reg]))
                begin
                    sel_reg     <= 1'b1;
                    sel_idx_reg <= ctl.idx;
                end
            end
            if (ee && !hit_reg && op == mrat_pkg::OP_LOOKUP)
            begin
                if (e_cov)
                begin
                    hit_reg     <= 1'b1;
                    hit_lo_reg  <= elo;
                    hit_hi_reg  <= ehi;
                    hit_num_reg <= num_mem[ctl.idx];
                    hit_att_reg <= att_mem[ctl.idx];
                end
                else
                begin
                    if ((c_reg.address >= ehi) && (gap_lo_reg < ehi))
                        gap_lo_reg <= ehi;
                    if ((c_reg.address <= elo) && ((gap_hi_reg == 64'd0) || (gap_hi_reg > elo)))
                        gap_hi_reg <= elo;
                end
            end
        end
        if (ctl.finish && op == mrat_pkg::OP_INSERT && st == mrat_pkg::ST_OK)
        begin
            lo_mem[free_idx]  <= c_reg.addr_low;
            hi_mem[free_idx]  <= c_reg.addr_high;
            num_mem[free_idx] <= num_inc;
            att_mem[free_idx] <= {c_reg.cacheable, awidth, amode};
        end
    end

    always_comb
    begin
        st = mrat_pkg::ST_OK;
        unique case (op)
            mrat_pkg::OP_INSERT:
            begin
                priority if (misaligned) st = mrat_pkg::ST_MISALIGNED;
                else if (bad_bounds)     st = mrat_pkg::ST_BOUNDS;
                else if (ovl_reg)        st = mrat_pkg::ST_OVERLAP;
                else if (!free_any)      st = mrat_pkg::ST_FULL;
                else                     st = mrat_pkg::ST_OK;
            end
            mrat_pkg::OP_ENABLE, mrat_pkg::OP_DISABLE:
                st = sel_reg ? mrat_pkg::ST_OK : mrat_pkg::ST_NOT_FOUND;
            mrat_pkg::OP_DELETE:
                st = (match_reg != '0) ? mrat_pkg::ST_OK : mrat_pkg::ST_NOT_FOUND;
            default:
                st = mrat_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            en_reg          <= '0;
            next_number_reg <= 16'd0;
            done            <= 1'b0;
        end
        else
        begin
            done <= ctl.finish;
            if (ctl.finish)
            begin
                unique case (op)
                    mrat_pkg::OP_INSERT:
                        if (st == mrat_pkg::ST_OK)
                        begin
                            valid_reg[free_idx] <= 1'b1;
                            en_reg[free_idx]    <= 1'b1;
                            next_number_reg     <= num_inc;
                        end
                    mrat_pkg::OP_ENABLE:
                        if (sel_reg) en_reg[sel_idx_reg] <= 1'b1;
                    mrat_pkg::OP_DISABLE:
                        if (sel_reg) en_reg[sel_idx_reg] <= 1'b0;
                    mrat_pkg::OP_DELETE:
                        valid_reg <= valid_reg & ~match_reg;
                    mrat_pkg::OP_CLEAR_ALL:
                        valid_reg <= '0;
                    mrat_pkg::OP_ENABLE_ALL:
                        en_reg <= '1;
                    mrat_pkg::OP_DISABLE_ALL:
                        en_reg <= '0;
                    default:
                        en_reg <= en_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        rsp_next        = '0;
        rsp_next.status = st;
        if (op == mrat_pkg::OP_INSERT && st == mrat_pkg::ST_OK)
            rsp_next.result_number = num_inc;
        if (op == mrat_pkg::OP_LOOKUP)
        begin
            if (hit_reg)
            begin
                rsp_next.found         = 1'b1;
                rsp_next.result_low    = hit_lo_reg;
                rsp_next.result_high   = hit_hi_reg;
                rsp_next.result_number = hit_num_reg;
                rsp_next.result_mode   = hit_att_reg[1:0];
                rsp_next.result_width  = hit_att_reg[4:2];
                rsp_next.result_cache  = hit_att_reg[5];
            end
            else
            begin
                rsp_next.result_low   = gap_lo_reg;
                rsp_next.result_high  = gap_hi_reg;
                // any stored region counts, also past the scan end
                rsp_next.attr_unknown = unknown_inaccessible && (valid_reg != '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
            result <= rsp_next;
    end

    a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.finish && op == mrat_pkg::OP_INSERT && st == mrat_pkg::ST_OK)
        |=> $countones(valid_reg) == $past($countones(valid_reg)) + 1)
        else $error("insert did not fill exactly one slot");
    a_nonzero_num: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.finish && op == mrat_pkg::OP_INSERT) |-> num_inc != 16'd0)
        else $error("assigned region number zero");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.finish && op == mrat_pkg::OP_CLEAR_ALL) |=> valid_reg == '0)
        else $error("clear all left entries");

endmodule

// ===== bench/memory_region_attribute_table_tb.sv =====
`timescale 1ns / 100ps

module memory_region_attribute_table_tb;
    import mrat_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BEATS   = 850;
    localparam int TAIL_CYCLES    = 40;

    logic clk;
    logic rst_n;
    logic start;
    cmd_t cmd;
    logic busy;
    logic done;
    rsp_t result;
    logic cfg_we;
    logic cfg_data;

    memory_region_attribute_table dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the region table, updated as each command is accepted.
    logic        tbl_valid   [MAX_REGIONS];
    logic        tbl_enabled [MAX_REGIONS];
    logic [63:0] tbl_low     [MAX_REGIONS];
    logic [63:0] tbl_high    [MAX_REGIONS];
    logic [15:0] tbl_number  [MAX_REGIONS];
    logic [1:0]  tbl_amode   [MAX_REGIONS];
    logic [2:0]  tbl_awidth  [MAX_REGIONS];
    logic        tbl_cache   [MAX_REGIONS];
    logic [15:0] last_number;
    logic        gap_unknown;

    rsp_t pending_rsp[$];
    int   mismatches;
    int   idle_cycles;
    bit   timed_out;

    // Directed table: expected result is checked only when has_exp is set.
    typedef struct {
        cmd_t c;
        bit   has_exp;
        rsp_t e;
    } vector_t;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic bit region_covers(logic [63:0] lo, logic [63:0] hi, logic [63:0] a);
        return a >= lo && (a < hi || hi == 64'd0);
    endfunction

    function automatic bit regions_overlap(logic [63:0] lo, logic [63:0] hi,
                                           logic [63:0] nlo, logic [63:0] nhi);
        if (lo >= nlo)
            return lo < nhi || nhi == 64'd0;
        return hi > nlo || hi == 64'd0;
    endfunction

    // Compute the table's answer to one command and advance the shadow table.
    function automatic rsp_t table_response(cmd_t c);
        rsp_t r;
        logic [1:0]  am;
        logic [2:0]  aw;
        logic [63:0] mask;
        logic [63:0] glo;
        logic [63:0] ghi;
        bit any;
        int slot;
        int k;
        r = '0;
        case (op_t'(c.mode))
            OP_INSERT:
            begin
                am = (c.access_mode == 2'd3) ? 2'd0 : c.access_mode;
                aw = (c.access_width > 3'd4) ? 3'd0 : c.access_width;
                mask = (aw == 3'd2) ? 64'd1 : (aw == 3'd3) ? 64'd3 : (aw == 3'd4) ? 64'd7 : 64'd0;
                r.status = ST_OK;
                slot = -1;
                if (((c.addr_low | c.addr_high) & mask) != 64'd0)
                    r.status = ST_MISALIGNED;
                else if (c.addr_low >= c.addr_high && c.addr_high != 64'd0)
                    r.status = ST_BOUNDS;
                else
                begin
                    for (int i = 0; i < MAX_REGIONS; i++)
                        if (tbl_valid[i] && regions_overlap(c.addr_low, c.addr_high,
                                                           tbl_low[i], tbl_high[i]))
                            r.status = ST_OVERLAP;
                    if (r.status == ST_OK)
                    begin
                        for (int i = MAX_REGIONS - 1; i >= 0; i--)
                            if (!tbl_valid[i])
                                slot = i;
                        if (slot < 0)
                            r.status = ST_FULL;
                    end
                end
                if (r.status == ST_OK)
                begin
                    last_number = (last_number == 16'hFFFF) ? 16'd1 : last_number + 16'd1;
                    tbl_valid[slot]   = 1'b1;
                    tbl_enabled[slot] = 1'b1;
                    tbl_low[slot]     = c.addr_low;
                    tbl_high[slot]    = c.addr_high;
                    tbl_number[slot]  = last_number;
                    tbl_amode[slot]   = am;
                    tbl_awidth[slot]  = aw;
                    tbl_cache[slot]   = c.cacheable;
                    r.result_number   = last_number;
                end
            end
            OP_LOOKUP:
            begin
                glo = '0;
                ghi = '0;
                any = 0;
                for (int i = 0; i < MAX_REGIONS; i++)
                    any |= tbl_valid[i];
                // The first enabled region in slot order that holds the address wins.
                for (int i = 0; i < MAX_REGIONS && !r.found; i++)
                begin
                    if (!tbl_valid[i] || !tbl_enabled[i])
                        continue;
                    if (region_covers(tbl_low[i], tbl_high[i], c.address))
                    begin
                        r.found         = 1'b1;
                        r.result_low    = tbl_low[i];
                        r.result_high   = tbl_high[i];
                        r.result_number = tbl_number[i];
                        r.result_mode   = tbl_amode[i];
                        r.result_width  = tbl_awidth[i];
                        r.result_cache  = tbl_cache[i];
                    end
                    else
                    begin
                        if (c.address >= tbl_high[i] && glo < tbl_high[i])
                            glo = tbl_high[i];
                        if (c.address <= tbl_low[i] && (ghi == 64'd0 || ghi > tbl_low[i]))
                            ghi = tbl_low[i];
                    end
                end
                if (!r.found)
                begin
                    r.result_low   = glo;
                    r.result_high  = ghi;
                    r.attr_unknown = gap_unknown && any;
                end
            end
            OP_ENABLE, OP_DISABLE:
            begin
                k = -1;
                for (int i = 0; i < MAX_REGIONS; i++)
                    if (tbl_valid[i] && tbl_number[i] == c.region_number &&
                        (k < 0 || tbl_low[i] < tbl_low[k]))
                        k = i;
                if (k < 0)
                    r.status = ST_NOT_FOUND;
                else
                    tbl_enabled[k] = (op_t'(c.mode) == OP_ENABLE);
            end
            OP_DELETE:
            begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < MAX_REGIONS; i++)
                    if (tbl_valid[i] && tbl_number[i] == c.region_number)
                    begin
                        tbl_valid[i] = 1'b0;
                        r.status = ST_OK;
                    end
            end
            OP_CLEAR_ALL:
                for (int i = 0; i < MAX_REGIONS; i++)
                    tbl_valid[i] = 1'b0;
            default:
                for (int i = 0; i < MAX_REGIONS; i++)
                    tbl_enabled[i] = (op_t'(c.mode) == OP_ENABLE_ALL);
        endcase
        return r;
    endfunction

    // Check each done beat against the oldest expectation.
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", result);
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (result !== exp_rsp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d f=%0d lo=%h hi=%h n=%0d m=%0d w=%0d c=%0d u=%0d\n          got st=%0d f=%0d lo=%h hi=%h n=%0d m=%0d w=%0d c=%0d u=%0d",
                            exp_rsp.status, exp_rsp.found, exp_rsp.result_low,
                            exp_rsp.result_high, exp_rsp.result_number, exp_rsp.result_mode,
                            exp_rsp.result_width, exp_rsp.result_cache, exp_rsp.attr_unknown,
                            result.status, result.found, result.result_low,
                            result.result_high, result.result_number, result.result_mode,
                            result.result_width, result.result_cache, result.attr_unknown);
                end
            end
        end
    end

    // Watchdog: count cycles with neither a command nor a result beat.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("FAIL memory_region_attribute_table");
            $finish;
        end
    end

    // Drive one command and hold start until the beat is taken.
    task automatic issue_beat(cmd_t c, bit has_exp, rsp_t e);
        rsp_t r;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = table_response(c);
        pending_rsp.push_back(r);
        if (has_exp && r !== e)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("predictor disagrees with directed row, mode %0d", c.mode);
        end
    endtask

    task automatic drop_start();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Drain, let the block settle, then write the register.
    task automatic write_unknown_flag(logic v);
        drop_start();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        gap_unknown = v;
    endtask

    function automatic cmd_t make_cmd(op_t op, logic [63:0] lo, logic [63:0] hi,
                                      logic [63:0] a, logic [15:0] n,
                                      logic [1:0] am, logic [2:0] aw, logic ca);
        cmd_t c;
        c.mode = op;  c.addr_low = lo;  c.addr_high = hi;  c.address = a;
        c.region_number = n;  c.access_mode = am;  c.access_width = aw;  c.cacheable = ca;
        return c;
    endfunction

    function automatic rsp_t status_rsp(logic [2:0] st, logic [15:0] n);
        rsp_t r;
        r = '0;
        r.status = st;
        r.result_number = n;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Addresses mostly from a small window so regions collide and gaps are found often.
    function automatic logic [63:0] pick_addr();
        case ($urandom_range(0, 5))
            0: return rand64();
            1: return 64'hFFFF_FFFF_FFFF_FFF0 + $urandom_range(0, 15);
            default: return 64'(($urandom_range(0, 4095)) << 2);
        endcase
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        logic [63:0] lo;
        int pick;
        c = '0;
        c.access_mode  = $urandom_range(0, 3);
        c.access_width = $urandom_range(0, 7);
        c.cacheable    = $urandom_range(0, 1);
        c.addr_low     = rand64();
        c.addr_high    = rand64();
        c.address      = pick_addr();
        c.region_number = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                                      : last_number - 16'($urandom_range(0, 20));
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            c.mode = OP_INSERT;
            // Mostly well-formed, small and aligned regions; occasionally raw noise.
            if ($urandom_range(0, 7) != 0)
            begin
                lo = pick_addr() & ~64'd7;
                c.addr_low  = lo;
                c.addr_high = ($urandom_range(0, 15) == 0) ? 64'd0
                                                          : lo + 8 * $urandom_range(1, 40);
            end
        end
        else if (pick < 70) c.mode = OP_LOOKUP;
        else if (pick < 78) c.mode = OP_ENABLE;
        else if (pick < 86) c.mode = OP_DISABLE;
        else if (pick < 94) c.mode = OP_DELETE;
        else if (pick < 96) c.mode = OP_CLEAR_ALL;
        else if (pick < 98) c.mode = OP_ENABLE_ALL;
        else c.mode = OP_DISABLE_ALL;
        return c;
    endfunction

    initial
    begin
        vector_t rows[$];
        vector_t v;
        rsp_t    gap;
        int      burst;
        logic [63:0] ones;
        rst_n    = 1'b0;
        start    = 1'b0;
        cmd      = '0;
        cfg_we   = 1'b0;
        cfg_data = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        last_number = '0;
        gap_unknown = 1'b1;
        ones = '1;
        for (int i = 0; i < MAX_REGIONS; i++)
        begin
            tbl_valid[i] = 0;  tbl_enabled[i] = 0;  tbl_low[i] = 0;  tbl_high[i] = 0;
            tbl_number[i] = 0; tbl_amode[i] = 0;  tbl_awidth[i] = 0; tbl_cache[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: empty-table lookup, error codes, extremes, all ops.
        gap = '0;
        rows.push_back('{make_cmd(OP_LOOKUP, 0, 0, ones, 0, 0, 0, 0), 1, gap});
        rows.push_back('{make_cmd(OP_ENABLE, 0, 0, 0, 0, 0, 0, 0), 1, status_rsp(ST_NOT_FOUND, 0)});
        rows.push_back('{make_cmd(OP_DELETE, 0, 0, 0, 16'hFFFF, 0, 0, 0), 1,
                         status_rsp(ST_NOT_FOUND, 0)});
        rows.push_back('{make_cmd(OP_INSERT, 64'h2, 64'h10, 0, 0, 0, 3'd3, 0), 1,
                         status_rsp(ST_MISALIGNED, 0)});
        rows.push_back('{make_cmd(OP_INSERT, 64'h10, 64'h10, 0, 0, 0, 0, 0), 1,
                         status_rsp(ST_BOUNDS, 0)});
        rows.push_back('{make_cmd(OP_INSERT, 64'h100, 64'h200, 0, 0, 2'd1, 3'd4, 1), 1,
                         status_rsp(ST_OK, 1)});
        rows.push_back('{make_cmd(OP_INSERT, 64'h180, 64'h300, 0, 0, 0, 0, 0), 1,
                         status_rsp(ST_OVERLAP, 0)});
        rows.push_back('{make_cmd(OP_INSERT, ones - 7, 0, 0, 0, 2'd3, 3'd7, 0), 1,
                         status_rsp(ST_OK, 2)});
        rows.push_back('{make_cmd(OP_INSERT, 64'h0, 64'h1, 0, 0, 2'd2, 3'd1, 1), 0, gap});
        rows.push_back('{make_cmd(OP_INSERT, 64'h400, 64'h0, 0, 0, 0, 3'd2, 0), 0, gap});
        rows.push_back('{make_cmd(OP_LOOKUP, 0, 0, 64'h1ff, 0, 0, 0, 0), 0, gap});
        rows.push_back('{make_cmd(OP_LOOKUP, 0, 0, ones, 0, 0, 0, 0), 0, gap});
        rows.push_back('{make_cmd(OP_LOOKUP, 0, 0, 64'h250, 0, 0, 0, 0), 0, gap});
        rows.push_back('{make_cmd(OP_DISABLE, 0, 0, 0, 16'd1, 0, 0, 0), 0, gap});
        rows.push_back('{make_cmd(OP_LOOKUP, 0, 0, 64'h100, 0, 0, 0, 0), 0, gap});
        rows.push_back('{make_cmd(OP_ENABLE, 0, 0, 0, 16'd1, 0, 0, 0), 0, gap});
        rows.push_back('{make_cmd(OP_DISABLE_ALL, 0, 0, 0, 0, 0, 0, 0), 0, gap});
        rows.push_back('{make_cmd(OP_LOOKUP, 0, 0, 64'h150, 0, 0, 0, 0), 0, gap});
        rows.push_back('{make_cmd(OP_ENABLE_ALL, 0, 0, 0, 0, 0, 0, 0), 0, gap});
        rows.push_back('{make_cmd(OP_DELETE, 0, 0, 0, 16'd2, 0, 0, 0), 0, gap});
        rows.push_back('{make_cmd(OP_CLEAR_ALL, 0, 0, 0, 0, 0, 0, 0), 0, gap});
        rows.push_back('{make_cmd(OP_LOOKUP, 0, 0, 64'h5, 0, 0, 0, 0), 1, gap});
        foreach (rows[i])
            issue_beat(rows[i].c, rows[i].has_exp, rows[i].e);

        // Gap lookup with the flag cleared, then set again.
        write_unknown_flag(1'b0);
        issue_beat(make_cmd(OP_INSERT, 64'h40, 64'h80, 0, 0, 0, 0, 0), 0, gap);
        issue_beat(make_cmd(OP_LOOKUP, 0, 0, 64'h0, 0, 0, 0, 0), 0, gap);
        write_unknown_flag(1'b1);
        issue_beat(make_cmd(OP_LOOKUP, 0, 0, 64'h0, 0, 0, 0, 0), 0, gap);

        // Random part: bursts of commands with random gaps; write the flag with a
        // random value between phases.
        for (int n = 0; n < RANDOM_BEATS; )
        begin
            burst = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 12);
            for (int b = 0; b < burst && n < RANDOM_BEATS; b++, n++)
                issue_beat(random_cmd(), 0, gap);
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
            if (n % 200 < burst)
                write_unknown_flag($urandom_range(0, 1));
        end

        drop_start();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS memory_region_attribute_table");
        else
            $display("FAIL memory_region_attribute_table");
        $finish;
    end
endmodule

// ===== memory_region_attribute_table.f =====
sv/mrat_pkg.sv
sv/mrat_ctrl.sv
sv/mrat_dp.sv
sv/memory_region_attribute_table.sv
bench/memory_region_attribute_table_tb.sv
